// ===== hdl/pcd_pkg.sv =====
`timescale 1ns / 1ps
package pcd_pkg;

  localparam int NUM_TILES = 16;
  localparam int TILE_W    = 4;
  localparam int PART_W    = 4;
  localparam int IDX_W     = 10;
  localparam int FUNC_W    = 2;
  localparam int KIND_W    = 3;
  localparam int STATE_W   = 2;
  localparam int SCHEME_W  = 3;
  localparam int ENTRY_W   = STATE_W + NUM_TILES;
  localparam int QDEPTH    = 2;
  localparam int MAX_NOTIFY = 15;

  // request kinds
  localparam logic [FUNC_W-1:0] FN_READ = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RDX  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UPG  = 2'd2;

  // entry states
  localparam logic [STATE_W-1:0] DST_I  = 2'd0;
  localparam logic [STATE_W-1:0] DST_S  = 2'd1;
  localparam logic [STATE_W-1:0] DST_EM = 2'd2;
  localparam logic [STATE_W-1:0] DST_BAD = 2'd3;

  // message kinds
  localparam logic [KIND_W-1:0] K_INV  = 3'd0;
  localparam logic [KIND_W-1:0] K_INT  = 3'd1;
  localparam logic [KIND_W-1:0] K_DATA = 3'd2;
  localparam logic [KIND_W-1:0] K_ACK  = 3'd3;
  localparam logic [KIND_W-1:0] K_NONE = 3'd4;
  localparam logic [KIND_W-1:0] K_ERR  = 3'd5;

  // partition schemes
  localparam logic [SCHEME_W-1:0] SCH_1 = 3'd0;
  localparam logic [SCHEME_W-1:0] SCH_2 = 3'd1;
  localparam logic [SCHEME_W-1:0] SCH_4 = 3'd2;
  localparam logic [SCHEME_W-1:0] SCH_8 = 3'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    logic [TILE_W-1:0] tile;
    logic [PART_W-1:0] part;
  } req_t;

  function automatic logic [PART_W-1:0] tile_to_part(input logic [SCHEME_W-1:0] scheme,
                                                     input logic [TILE_W-1:0] t);
    logic [PART_W-1:0] p;
    case (scheme)
      SCH_1:   p = t;
      SCH_2:   p = {1'b0, t[3:1]};
      SCH_4:   p = {2'b00, t[3], t[1]};
      SCH_8:   p = {3'b000, ~t[3]};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/partitioned_coherence_directory.sv =====
`timescale 1ns / 1ps
// Directory controller for 16 tiles grouped into partitions by part_scheme. A request
// sends n (0 to 15) invalidations or interventions and then its final reply: it leaves the
// input queue, its entry is read through the directory RAM's registered port, then the
// back-end sequencer gives one result per cycle while the output is not stalled, the final
// reply last. A two-deep queue lets new requests be taken while results wait. After reset
// a clearing pass writes every entry, during which s_axis_tready stays low; configuration
// writes are taken at any time.
module partitioned_coherence_directory #(
  parameter int DIR_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,        // part_scheme
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,    // func[1:0], block_index[11:2], from_tile[15:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // msg_kind[2:0], target_part[6:3], target_tile[10:7],
                                       // new_state[12:11], zero[15:13]
  output logic        m_axis_tlast
);
  import pcd_pkg::*;

  localparam int AW = $clog2(DIR_DEPTH);

  logic               clearing;
  logic               push;
  logic               push_ready;
  req_t               push_data;
  logic               pop;
  logic               pop_valid;
  req_t               pop_data;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KIND_W-1:0]  msg_kind;
  logic [PART_W-1:0]  target_part;
  logic [TILE_W-1:0]  target_tile;
  logic [STATE_W-1:0] new_state;

  pcd_front #(.DIR_DEPTH(DIR_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .s_valid     (s_axis_tvalid),
    .s_ready     (s_axis_tready),
    .func        (s_axis_tdata[1:0]),
    .block_index (s_axis_tdata[11:2]),
    .from_tile   (s_axis_tdata[15:12]),
    .clearing    (clearing),
    .push        (push),
    .push_data   (push_data),
    .push_ready  (push_ready)
  );

  pcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  pcd_ram #(.WIDTH(ENTRY_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcd_back #(.DIR_DEPTH(DIR_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (pop_valid),
    .q_data      (pop_data),
    .q_pop       (pop),
    .clearing    (clearing),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .msg_kind    (msg_kind),
    .target_part (target_part),
    .target_tile (target_tile),
    .new_state   (new_state),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, new_state, target_tile, target_part, msg_kind};

`ifndef SYNTHESIS
  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(s_axis_tvalid && s_axis_tready))
    else $error("request accepted during directory clearing pass");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_axis_tvalid)
    else $error("result shown during directory clearing pass");

  a_mid_result_is_probe: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |->
      (msg_kind == K_INV || msg_kind == K_INT))
    else $error("non-final result is not an invalidate or intervene");

  a_error_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && msg_kind == K_ERR) |-> m_axis_tlast)
    else $error("error result not marked last");
`endif

endmodule

// ===== hdl/pcd_ram.sv =====
`timescale 1ns / 1ps
module pcd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pcd_queue.sv =====
`timescale 1ns / 1ps
module pcd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcd_pkg::req_t push_data,
  output logic          push_ready,
  input  logic          pop,
  output pcd_pkg::req_t pop_data,
  output logic          pop_valid
);
  import pcd_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  req_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pcd_front.sv =====
`timescale 1ns / 1ps
module pcd_front #(
  parameter int DIR_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcd_pkg::SCHEME_W-1:0]   cfg_data,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  logic [pcd_pkg::FUNC_W-1:0]     func,
  input  logic [pcd_pkg::IDX_W-1:0]      block_index,
  input  logic [pcd_pkg::TILE_W-1:0]     from_tile,
  input  logic                           clearing,
  output logic                           push,
  output pcd_pkg::req_t                  push_data,
  input  logic                           push_ready
);
  import pcd_pkg::*;

  // depth is at least 16, so the quotient of a 10-bit index fits in IDX_W-4 bits
  localparam int RED_STEPS = IDX_W - 4;
  localparam int CMP_W = IDX_W + 32;

  logic [SCHEME_W-1:0] part_scheme;
  logic [IDX_W-1:0]    idx_red;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_scheme <= SCH_1;
    end else if (cfg_valid) begin
      part_scheme <= cfg_data;
    end
  end

  // index modulo depth by restoring subtraction of shifted depths
  always_comb begin
    idx_red = block_index;
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (CMP_W'(idx_red) >= (CMP_W'(DIR_DEPTH) << k)) begin
        idx_red = idx_red - IDX_W'(CMP_W'(DIR_DEPTH) << k);
      end
    end
  end

  assign s_ready        = push_ready && !clearing;
  assign push           = s_valid && s_ready;
  assign push_data.func = func;
  assign push_data.idx  = idx_red;
  assign push_data.tile = from_tile;
  assign push_data.part = tile_to_part(part_scheme, from_tile);

endmodule

// ===== hdl/pcd_back.sv =====
`timescale 1ns / 1ps
module pcd_back #(
  parameter int DIR_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  pcd_pkg::req_t                    q_data,
  output logic                             q_pop,
  output logic                             clearing,
  output logic                             ram_we,
  output logic [$clog2(DIR_DEPTH)-1:0]     ram_waddr,
  output logic [pcd_pkg::ENTRY_W-1:0]      ram_wdata,
  output logic [$clog2(DIR_DEPTH)-1:0]     ram_raddr,
  input  logic [pcd_pkg::ENTRY_W-1:0]      ram_rdata,
  output logic                             m_valid,
  input  logic                             m_ready,
  output logic [pcd_pkg::KIND_W-1:0]       msg_kind,
  output logic [pcd_pkg::PART_W-1:0]       target_part,
  output logic [pcd_pkg::TILE_W-1:0]       target_tile,
  output logic [pcd_pkg::STATE_W-1:0]      new_state,
  output logic                             last
);
  import pcd_pkg::*;

  localparam int AW = $clog2(DIR_DEPTH);
  localparam int CNT_W = $clog2(MAX_NOTIFY + 1);

  typedef enum logic [3:0] {
    BK_CLEAR = 4'b0001,
    BK_IDLE  = 4'b0010,
    BK_READ  = 4'b0100,
    BK_EMIT  = 4'b1000
  } back_state_t;

  back_state_t          state;
  back_state_t          state_next;
  logic [AW-1:0]        clr_addr;
  req_t                 req;
  logic [NUM_TILES-1:0] notify;
  logic [KIND_W-1:0]    notify_kind;
  logic [KIND_W-1:0]    final_kind;
  logic [STATE_W-1:0]   final_state;
  logic [CNT_W-1:0]     sent;

  // decode of the entry just read
  logic [STATE_W-1:0]   cur_st;
  logic [NUM_TILES-1:0] cur_sh;
  logic [NUM_TILES-1:0] pbit;
  logic [NUM_TILES-1:0] dec_notify;
  logic [NUM_TILES-1:0] dec_clear;
  logic [KIND_W-1:0]    dec_msgk;
  logic [KIND_W-1:0]    dec_kind;
  logic [STATE_W-1:0]   dec_nst;
  logic                 dec_err;

  logic                 out_free;
  logic                 emit_notify;
  logic [PART_W-1:0]    low_part;

  always_comb begin
    cur_st     = ram_rdata[ENTRY_W-1:NUM_TILES];
    cur_sh     = ram_rdata[NUM_TILES-1:0];
    pbit       = NUM_TILES'(1) << req.part;
    dec_notify = '0;
    dec_clear  = '0;
    dec_msgk   = K_INV;
    dec_kind   = K_ERR;
    dec_nst    = DST_I;
    dec_err    = 1'b0;
    if (cur_st == DST_BAD) begin
      cur_st = DST_I;
    end
    case (req.func)
      FN_READ: begin
        dec_kind = K_DATA;
        if (cur_st == DST_EM) begin
          dec_notify = cur_sh;
          dec_msgk   = K_INT;
          dec_nst    = DST_S;
        end else if (cur_st == DST_S) begin
          dec_nst = DST_S;
        end else begin
          dec_nst = DST_EM;
        end
      end
      FN_RDX: begin
        dec_nst = DST_EM;
        if (cur_st == DST_I) begin
          dec_kind = K_NONE;
        end else begin
          dec_notify = cur_sh & ~pbit;
          dec_clear  = dec_notify;
          dec_kind   = (cur_st == DST_EM) ? K_DATA : K_NONE;
        end
      end
      FN_UPG: begin
        if (cur_st == DST_S) begin
          dec_notify = cur_sh & ~pbit;
          dec_clear  = dec_notify;
          dec_kind   = K_ACK;
          dec_nst    = DST_EM;
        end else begin
          dec_err = 1'b1;
          dec_nst = cur_st;
        end
      end
      default: begin
        dec_err = 1'b1;
        dec_nst = cur_st;
      end
    endcase
  end

  // lowest pending sharer partition
  always_comb begin
    low_part = '0;
    for (int q = NUM_TILES - 1; q >= 0; q--) begin
      if (notify[q]) begin
        low_part = PART_W'(q);
      end
    end
  end

  assign out_free    = !m_valid || m_ready;
  assign emit_notify = (notify != '0) && (sent != CNT_W'(MAX_NOTIFY));
  assign clearing    = (state == BK_CLEAR);
  assign q_pop       = (state == BK_IDLE);
  assign ram_raddr   = AW'(q_data.idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(req.idx);
    ram_wdata = {dec_nst, (cur_sh & ~dec_clear) | pbit};
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      BK_READ: ram_we = !dec_err;
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr_addr == AW'(DIR_DEPTH - 1)) state_next = BK_IDLE;
      BK_IDLE:  if (q_valid) state_next = BK_READ;
      BK_READ:  state_next = BK_EMIT;
      BK_EMIT:  if (out_free && !emit_notify) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_CLEAR;
      clr_addr <= '0;
      m_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == BK_EMIT && out_free) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid) begin
      req <= q_data;
    end
    if (state == BK_READ) begin
      notify      <= dec_notify;
      notify_kind <= dec_msgk;
      final_kind  <= dec_kind;
      final_state <= dec_nst;
      sent        <= '0;
    end
    if (state == BK_EMIT && out_free) begin
      target_tile <= req.tile;
      new_state   <= final_state;
      if (emit_notify) begin
        msg_kind    <= notify_kind;
        target_part <= low_part;
        last        <= 1'b0;
        notify      <= notify & (notify - 1'b1);
        sent        <= sent + 1'b1;
      end else begin
        msg_kind    <= final_kind;
        target_part <= req.part;
        last        <= 1'b1;
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pcd_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PART_W-1:0]  part;
    logic [TILE_W-1:0]  tile;
    logic [STATE_W-1:0] state;
    logic               last;
  } msg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [IDX_W-1:0]   idx;
    logic [TILE_W-1:0]  tile;
    logic               typed;
    logic [KIND_W-1:0]  kind;
    logic [PART_W-1:0]  part;
    logic [STATE_W-1:0] state;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  partitioned_coherence_directory dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // directory image kept alongside the block
  logic [STATE_W-1:0]   dir_state   [1024];
  logic [NUM_TILES-1:0] dir_sharers [1024];
  logic [SCHEME_W-1:0]  cur_scheme;

  msg_t fresh_msgs[$];
  msg_t awaited_msgs[$];
  int   error_count;
  bit   calm;

  stim_row_t directed_rows [17];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous ceiling, well above the slowest legal run including the clearing pass
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PART_W-1:0] partition_of(input logic [SCHEME_W-1:0] scheme,
                                                     input logic [TILE_W-1:0] t);
    case (scheme)
      SCH_1:   partition_of = t;
      SCH_2:   partition_of = t >> 1;
      SCH_4:   partition_of = {2'b00, t[3], t[1]};
      SCH_8:   partition_of = (t < 4'd8) ? 4'd1 : 4'd0;
      default: partition_of = 4'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // works out the messages one request causes and updates the directory image
  task automatic predict_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                                 input logic [TILE_W-1:0] tile);
    logic [PART_W-1:0]    p;
    logic [STATE_W-1:0]   st;
    logic [STATE_W-1:0]   nxt;
    logic [NUM_TILES-1:0] sh;
    logic [NUM_TILES-1:0] notify;
    logic [KIND_W-1:0]    final_kind;
    logic [KIND_W-1:0]    note_kind;
    bit                   strip;
    bit                   refused;
    int                   sent;
    p = partition_of(cur_scheme, tile);
    st = dir_state[idx];
    if (st == DST_BAD) st = DST_I;
    sh = dir_sharers[idx];
    notify = '0;
    strip = 1'b0;
    refused = 1'b0;
    note_kind = K_INV;
    final_kind = K_ERR;
    nxt = st;
    sent = 0;
    case (f)
      FN_READ: begin
        final_kind = K_DATA;
        if (st == DST_EM) begin
          notify = sh;
          note_kind = K_INT;
          nxt = DST_S;
        end else if (st == DST_S) begin
          nxt = DST_S;
        end else begin
          nxt = DST_EM;
        end
      end
      FN_RDX: begin
        nxt = DST_EM;
        if (st == DST_I) begin
          final_kind = K_NONE;
        end else begin
          notify = sh & ~(16'd1 << p);
          strip = 1'b1;
          final_kind = (st == DST_EM) ? K_DATA : K_NONE;
        end
      end
      FN_UPG: begin
        if (st == DST_S) begin
          notify = sh & ~(16'd1 << p);
          strip = 1'b1;
          final_kind = K_ACK;
          nxt = DST_EM;
        end else begin
          refused = 1'b1;
        end
      end
      default: refused = 1'b1;
    endcase
    if (refused) begin
      fresh_msgs.push_back('{K_ERR, p, tile, st, 1'b1});
    end else begin
      for (int q = 0; q < NUM_TILES; q++) begin
        if (notify[q] && sent < MAX_NOTIFY) begin
          fresh_msgs.push_back('{note_kind, q[PART_W-1:0], tile, nxt, 1'b0});
          sent++;
        end
      end
      if (strip) sh = sh & ~notify;
      sh[p] = 1'b1;
      dir_state[idx] = nxt;
      dir_sharers[idx] = sh;
      fresh_msgs.push_back('{final_kind, p, tile, nxt, 1'b1});
    end
  endtask

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] idx,
                              input logic [TILE_W-1:0] tile, input bit typed,
                              input msg_t typed_msg);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {tile, idx, f};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(f, idx, tile);
    if (typed) begin
      awaited_msgs.push_back(typed_msg);
      fresh_msgs.delete();
    end else begin
      while (fresh_msgs.size() > 0) awaited_msgs.push_back(fresh_msgs.pop_front());
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_msgs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_scheme(input logic [SCHEME_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cur_scheme = value;
    cfg_valid <= 1'b0;
  endtask

  // sharer build-up on one entry from every tile, then an upgrade, then a mixed tail
  task automatic random_phase(input int n);
    logic [IDX_W-1:0]  pool [4];
    logic [FUNC_W-1:0] f;
    logic [IDX_W-1:0]  idx;
    int                start;
    int                step;
    int                r;
    msg_t              blank;
    blank = '0;
    foreach (pool[k]) pool[k] = IDX_W'($urandom_range(0, 1023));
    start = $urandom_range(0, 15);
    step = 2 * $urandom_range(0, 7) + 1;
    for (int i = 0; i < NUM_TILES; i++)
      send_request(FN_READ, pool[0], TILE_W'((start + i * step) % 16), 1'b0, blank);
    send_request(FN_UPG, pool[0], TILE_W'($urandom_range(0, 15)), 1'b0, blank);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        idx = pool[2'($urandom_range(0, 3))];
        r = $urandom_range(0, 99);
        f = (r < 55) ? FN_READ : (r < 75) ? FN_RDX : FN_UPG;
      end else begin
        idx = IDX_W'($urandom_range(0, 1023));
        f = FUNC_W'($urandom_range(0, 3));
      end
      send_request(f, idx, TILE_W'($urandom_range(0, 15)), 1'b0, blank);
    end
  endtask

  // result checking
  always @(posedge clk) begin
    msg_t got;
    msg_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[10:7],
              m_axis_tdata[12:11], m_axis_tlast};
      if (awaited_msgs.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d part %0d tile %0d",
                                  got.kind, got.part, got.tile));
      end else begin
        want = awaited_msgs.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("msg_kind got %0d want %0d", got.kind, want.kind));
        if (got.part !== want.part)
          report_mismatch($sformatf("target_part got %0d want %0d", got.part, want.part));
        if (got.tile !== want.tile)
          report_mismatch($sformatf("target_tile got %0d want %0d", got.tile, want.tile));
        if (got.state !== want.state)
          report_mismatch($sformatf("new_state got %0d want %0d", got.state, want.state));
        if (got.last !== want.last)
          report_mismatch($sformatf("tlast got %0d want %0d", got.last, want.last));
      end
    end
  end

  // result sink with random back-pressure
  initial begin
    int stall;
    int hold;
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = next_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin
    int   scheme_plan [8];
    msg_t typed_msg;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    error_count = 0;
    calm = 1'b0;
    cur_scheme = '0;
    foreach (dir_state[k]) begin
      dir_state[k] = DST_I;
      dir_sharers[k] = '0;
    end
    scheme_plan = '{1, 2, 3, 4, 7, 5, 6, 0};

    // scheme 0 after reset, so partition equals tile
    directed_rows = '{
      '{FN_READ,   10'h000, 4'd0,  1'b1, K_DATA, 4'd0,  DST_EM},
      '{FN_UPG,    10'h3ff, 4'd15, 1'b1, K_ERR,  4'd15, DST_I},
      '{FN_UNUSED, 10'h155, 4'd5,  1'b1, K_ERR,  4'd5,  DST_I},
      '{FN_READ,   10'h000, 4'd3,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_READ,   10'h000, 4'd15, 1'b0, K_INV,  4'd0,  DST_I},
      '{FN_UPG,    10'h000, 4'd7,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_UPG,    10'h000, 4'd7,  1'b1, K_ERR,  4'd7,  DST_EM},
      '{FN_RDX,    10'h000, 4'd8,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_RDX,    10'h2aa, 4'd10, 1'b1, K_NONE, 4'd10, DST_EM},
      '{FN_READ,   10'h2aa, 4'd10, 1'b0, K_INV,  4'd0,  DST_I},
      '{FN_RDX,    10'h2aa, 4'd1,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_UNUSED, 10'h000, 4'd0,  1'b1, K_ERR,  4'd0,  DST_EM},
      '{FN_RDX,    10'h000, 4'd8,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_READ,   10'h3ff, 4'd9,  1'b1, K_DATA, 4'd9,  DST_EM},
      '{FN_UPG,    10'h200, 4'd0,  1'b1, K_ERR,  4'd0,  DST_I},
      '{FN_READ,   10'h3ff, 4'd6,  1'b0, K_INV,  4'd0,  DST_I},
      '{FN_UPG,    10'h3ff, 4'd9,  1'b0, K_INV,  4'd0,  DST_I}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // the block holds tready low through its clearing pass
    foreach (directed_rows[i]) begin
      typed_msg = '{directed_rows[i].kind, directed_rows[i].part, directed_rows[i].tile,
                    directed_rows[i].state, 1'b1};
      send_request(directed_rows[i].func, directed_rows[i].idx, directed_rows[i].tile,
                   directed_rows[i].typed, typed_msg);
    end

    foreach (scheme_plan[i]) begin
      write_scheme(scheme_plan[i][2:0]);
      calm = (i == 3) || ($urandom_range(0, 4) == 0);
      random_phase(16);
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (awaited_msgs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_msgs.size()));
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pcd_pkg.sv
hdl/pcd_ram.sv
hdl/pcd_queue.sv
hdl/pcd_front.sv
hdl/pcd_back.sv
hdl/partitioned_coherence_directory.sv
sim/tb_top.sv
